FILE: design/pdga_pkg.sv
// Shared types, codes and constants of the Poisson disc grid acceptance engine.
// Used by every module of the block but pdga_queue; depends on nothing.
package pdga_pkg;

    // Default sizes handed to the top level parameters.
    localparam int GRID_SIDE_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // Neighborhood scan: a 5 x 5 window with its four corners skipped.
    localparam int WINDOW    = 5;
    localparam int NEIGHBORS = WINDOW * WINDOW - 4;
    localparam int NB_BITS   = $clog2(NEIGHBORS);
    localparam int HALF      = WINDOW / 2;

    // Row and column offsets of each scanned cell, biased by HALF.
    localparam logic [2:0] OFS_ROW [NEIGHBORS] = '{
        3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4};
    localparam logic [2:0] OFS_COL [NEIGHBORS] = '{
        3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd1, 3'd2, 3'd3};

    // Input action codes; bit one selects the distance test.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_SEED  = 2'd1;
    localparam int         ACT_TEST_BIT = 1;

    // Result status codes.
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_OUTSIDE  = 3'd1;
    localparam logic [2:0] ST_TOOCLOSE = 3'd2;
    localparam logic [2:0] ST_OFFGRID  = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    // Job kinds passed from the front end to the back end.
    localparam logic [1:0] JOB_CLEAR  = 2'd0;
    localparam logic [1:0] JOB_REPORT = 2'd1;
    localparam logic [1:0] JOB_STORE  = 2'd2;
    localparam logic [1:0] JOB_TEST   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_DISTANCE    = 3'd0;
    localparam logic [2:0] REG_MAP_WIDTH       = 3'd1;
    localparam logic [2:0] REG_MAP_HEIGHT      = 3'd2;
    localparam logic [2:0] REG_CELL_RECIPROCAL = 3'd3;
    localparam logic [2:0] REG_GRID_COLUMNS    = 3'd4;
    localparam logic [2:0] REG_GRID_ROWS       = 3'd5;

    // Configuration reset values.
    localparam logic [11:0] RST_MIN_DISTANCE    = 12'd8;
    localparam logic [12:0] RST_MAP_WIDTH       = 13'd256;
    localparam logic [12:0] RST_MAP_HEIGHT      = 13'd256;
    localparam logic [15:0] RST_CELL_RECIPROCAL = 16'd11585;
    localparam logic [6:0]  RST_GRID_COLUMNS    = 7'd46;
    localparam logic [6:0]  RST_GRID_ROWS       = 7'd46;

    typedef struct packed {
        logic [11:0] min_distance;
        logic [12:0] map_width;
        logic [12:0] map_height;
        logic [15:0] cell_reciprocal;
        logic [6:0]  grid_columns;
        logic [6:0]  grid_rows;
    } t_cfg;

    typedef struct packed {
        logic [5:0] cell_row;
        logic [5:0] cell_column;
        logic [2:0] status;
        logic       accepted;
    } t_result;

    // Grid size in use, limited to the physical side.
    function automatic logic [8:0] clamp_side(input logic [6:0] n, input int side);
        logic [8:0] s;
        s = 9'(side);
        return ({2'b00, n} < s) ? {2'b00, n} : s;
    endfunction

endpackage

FILE: design/pdga_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on nothing; the job word width is a parameter.
module pdga_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);

    logic [W-1:0] r_slot [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_slot[r_rptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wptr] <= i_push_data;
    end

endmodule

FILE: design/pdga_front.sv
// Front end: takes input transfers, range checks them and computes the cell.
// Depends on pdga_pkg; feeds jobs into pdga_queue.
module pdga_front #(
    parameter int GRID_SIDE  = pdga_pkg::GRID_SIDE_DEF,
    parameter int COORD_BITS = pdga_pkg::COORD_BITS_DEF,
    localparam int SIDE_BITS = $clog2(GRID_SIDE),
    localparam int JOB_W     = 2 + 3 + 2 * COORD_BITS + 2 * SIDE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdga_pkg::t_cfg    i_cfg,
    input  logic              i_enable,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [13:0]       i_point_x,
    input  logic [13:0]       i_point_y,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output logic [JOB_W-1:0]  o_job
);

    localparam int COORD_LIMIT = 1 << COORD_BITS;

    typedef struct packed {
        logic [1:0]            kind;
        logic [2:0]            status;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIDE_BITS-1:0]  col;
        logic [SIDE_BITS-1:0]  row;
    } t_job;

    // Stage zero: registered input and storable check.
    logic        r_v0;
    logic [1:0]  r_act0;
    logic [12:0] r_x0;
    logic [12:0] r_y0;
    logic        r_ok0;
    // Stage one: cell products and map check.
    logic        r_v1;
    logic [1:0]  r_act1;
    logic [12:0] r_x1;
    logic [12:0] r_y1;
    logic        r_ok1;
    logic        r_onmap1;
    logic [12:0] r_colw;
    logic [12:0] r_roww;

    logic        adv0;
    logic        adv1;
    logic        storable;
    logic [28:0] prod_x;
    logic [28:0] prod_y;
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic        testing;
    t_job        job;

    assign adv1    = r_v1 && i_job_ready;
    assign adv0    = r_v0 && (!r_v1 || adv1);
    assign o_ready = i_enable && (!r_v0 || adv0);

    assign storable = !i_point_x[13] && !i_point_y[13]
        && ({4'b0, i_point_x[12:0]} < 17'(COORD_LIMIT))
        && ({4'b0, i_point_y[12:0]} < 17'(COORD_LIMIT));

    assign prod_x = 29'(r_x0) * 29'(i_cfg.cell_reciprocal);
    assign prod_y = 29'(r_y0) * 29'(i_cfg.cell_reciprocal);

    // Two-stage pipeline with local flow control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (o_ready) r_v0 <= i_valid;
            else if (adv0) r_v0 <= 1'b0;
            if (adv0) r_v1 <= 1'b1;
            else if (adv1) r_v1 <= 1'b0;
        end
        if (o_ready) begin
            r_act0 <= i_action;
            r_x0   <= i_point_x[12:0];
            r_y0   <= i_point_y[12:0];
            r_ok0  <= storable;
        end
        if (adv0) begin
            r_act1   <= r_act0;
            r_x1     <= r_x0;
            r_y1     <= r_y0;
            r_ok1    <= r_ok0;
            r_onmap1 <= (r_x0 < i_cfg.map_width) && (r_y0 < i_cfg.map_height);
            r_colw   <= prod_x[28:16];
            r_roww   <= prod_y[28:16];
        end
    end

    // Classify the item into a job for the back end.
    assign cols    = pdga_pkg::clamp_side(i_cfg.grid_columns, GRID_SIDE);
    assign rows    = pdga_pkg::clamp_side(i_cfg.grid_rows, GRID_SIDE);
    assign testing = r_act1[pdga_pkg::ACT_TEST_BIT];

    always_comb begin
        job        = '0;
        job.x      = COORD_BITS'(r_x1);
        job.y      = COORD_BITS'(r_y1);
        job.col    = SIDE_BITS'(r_colw);
        job.row    = SIDE_BITS'(r_roww);
        job.kind   = testing ? pdga_pkg::JOB_TEST : pdga_pkg::JOB_STORE;
        job.status = pdga_pkg::ST_STORED;
        if (r_act1 == pdga_pkg::ACT_CLEAR) begin
            job.kind   = pdga_pkg::JOB_CLEAR;
            job.status = pdga_pkg::ST_CLEARED;
        end else if (!r_ok1 || (testing && !r_onmap1)) begin
            job.kind   = pdga_pkg::JOB_REPORT;
            job.status = pdga_pkg::ST_OUTSIDE;
        end else if ({1'b0, r_colw} >= {5'b0, cols} || {1'b0, r_roww} >= {5'b0, rows}) begin
            job.kind   = pdga_pkg::JOB_REPORT;
            job.status = pdga_pkg::ST_OFFGRID;
        end
    end

    assign o_job_valid = r_v1;
    assign o_job       = job;

endmodule

FILE: design/pdga_back.sv
// Back end: grid memory, clearing sweep, neighborhood scan and result register.
// Depends on pdga_pkg; takes jobs from pdga_queue.
module pdga_back #(
    parameter int GRID_SIDE  = pdga_pkg::GRID_SIDE_DEF,
    parameter int COORD_BITS = pdga_pkg::COORD_BITS_DEF,
    localparam int SIDE_BITS = $clog2(GRID_SIDE),
    localparam int JOB_W     = 2 + 3 + 2 * COORD_BITS + 2 * SIDE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdga_pkg::t_cfg      i_cfg,
    output logic                o_ready_init,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  logic [JOB_W-1:0]    i_job,
    output logic                o_valid,
    input  logic                i_ready,
    output pdga_pkg::t_result   o_result
);

    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int ENTRY_W   = 2 * COORD_BITS + 1;
    localparam int SB1       = SIDE_BITS + 1;
    localparam int SQ_W      = 2 * COORD_BITS + 1;
    localparam int CMP_W     = (SQ_W > 24) ? SQ_W : 24;

    typedef struct packed {
        logic [1:0]            kind;
        logic [2:0]            status;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIDE_BITS-1:0]  col;
        logic [SIDE_BITS-1:0]  row;
    } t_job;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_FINISH
    } t_state;

    t_state                      r_state;
    logic [CELL_BITS-1:0]        r_sweep;
    logic                        r_report;
    logic                        r_init;
    logic [COORD_BITS-1:0]       r_x;
    logic [COORD_BITS-1:0]       r_y;
    logic [SIDE_BITS-1:0]        r_col;
    logic [SIDE_BITS-1:0]        r_row;
    logic [pdga_pkg::NB_BITS-1:0] r_idx;
    logic                        r_store;
    pdga_pkg::t_result           r_res;
    logic                        r_hit;
    logic                        r_ovalid;
    pdga_pkg::t_result           r_out;
    logic [23:0]                 r_limit;

    // Distance pipeline.
    logic [ENTRY_W-1:0]          mem [CELLS];
    logic [ENTRY_W-1:0]          r_rd;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic [COORD_BITS-1:0]       r_dx;
    logic [COORD_BITS-1:0]       r_dy;
    logic [2*COORD_BITS-1:0]     r_sqx;
    logic [2*COORD_BITS-1:0]     r_sqy;

    t_job                        job;
    logic                        out_free;
    logic [8:0]                  cols;
    logic [8:0]                  rows;
    logic [SB1-1:0]              nr_p;
    logic [SB1-1:0]              nc_p;
    logic [SB1-1:0]              nr;
    logic [SB1-1:0]              nc;
    logic                        in_grid;
    logic [CELL_BITS-1:0]        raddr;
    logic                        we;
    logic [CELL_BITS-1:0]        waddr;
    logic [ENTRY_W-1:0]          wdata;
    logic [COORD_BITS-1:0]       ox;
    logic [COORD_BITS-1:0]       oy;
    logic [SQ_W-1:0]             dsum;
    logic                        last_sweep;
    logic                        last_idx;

    assign job          = i_job;
    assign out_free     = !r_ovalid || i_ready;
    assign o_job_ready  = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_result     = r_out;
    assign o_ready_init = r_init;
    assign cols = pdga_pkg::clamp_side(i_cfg.grid_columns, GRID_SIDE);
    assign rows = pdga_pkg::clamp_side(i_cfg.grid_rows, GRID_SIDE);
    assign last_sweep = (r_sweep == CELL_BITS'(CELLS - 1));
    assign last_idx   = (r_idx == pdga_pkg::NB_BITS'(pdga_pkg::NEIGHBORS - 1));

    // Neighbor cell address for the current scan step.
    always_comb begin
        nr_p = SB1'(r_row) + SB1'(pdga_pkg::OFS_ROW[r_idx]);
        nc_p = SB1'(r_col) + SB1'(pdga_pkg::OFS_COL[r_idx]);
        nr   = nr_p - SB1'(pdga_pkg::HALF);
        nc   = nc_p - SB1'(pdga_pkg::HALF);
        in_grid = (nr_p >= SB1'(pdga_pkg::HALF)) && (nc_p >= SB1'(pdga_pkg::HALF))
            && (10'(nr) < 10'(rows)) && (10'(nc) < 10'(cols));
        raddr = CELL_BITS'(nr) * CELL_BITS'(GRID_SIDE) + CELL_BITS'(nc);
    end

    // Write port: clearing sweep or storing an accepted point.
    always_comb begin
        we    = 1'b0;
        waddr = r_sweep;
        wdata = '0;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_state == S_FINISH && out_free && r_store) begin
            we    = 1'b1;
            waddr = CELL_BITS'(r_row) * CELL_BITS'(GRID_SIDE) + CELL_BITS'(r_col);
            wdata = {1'b1, r_x, r_y};
        end
    end

    // Grid memory with registered read.
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[raddr];
    end

    // Distance pipeline: differences, squares, compare.
    assign ox   = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign oy   = r_rd[COORD_BITS-1:0];
    assign dsum = SQ_W'(r_sqx) + SQ_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_SCAN) && in_grid;
            r_v2 <= r_v1 && r_rd[ENTRY_W-1];
            r_v3 <= r_v2;
        end
        r_dx    <= (ox > r_x) ? ox - r_x : r_x - ox;
        r_dy    <= (oy > r_y) ? oy - r_y : r_y - oy;
        r_sqx   <= r_dx * r_dx;
        r_sqy   <= r_dy * r_dy;
        r_limit <= i_cfg.min_distance * i_cfg.min_distance;
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sweep  <= '0;
            r_report <= 1'b0;
            r_init   <= 1'b0;
            r_ovalid <= 1'b0;
            r_hit    <= 1'b0;
            r_idx    <= '0;
            r_store  <= 1'b0;
        end else begin
            // The finish state loads the output register itself.
            if (r_ovalid && i_ready && r_state != S_FINISH) r_ovalid <= 1'b0;
            if (r_v3 && (CMP_W'(dsum) < CMP_W'(r_limit))) r_hit <= 1'b1;
            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (last_sweep) begin
                        r_init  <= 1'b1;
                        r_store <= 1'b0;
                        r_res   <= '{cell_row: '0, cell_column: '0,
                                     status: pdga_pkg::ST_CLEARED, accepted: 1'b0};
                        r_state <= r_report ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_x   <= job.x;
                        r_y   <= job.y;
                        r_col <= job.col;
                        r_row <= job.row;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        case (job.kind)
                            pdga_pkg::JOB_CLEAR: begin
                                r_sweep  <= '0;
                                r_report <= 1'b1;
                                r_state  <= S_CLEAR;
                            end
                            pdga_pkg::JOB_REPORT: begin
                                r_res   <= '{cell_row: '0, cell_column: '0,
                                             status: job.status, accepted: 1'b0};
                                r_store <= 1'b0;
                                r_state <= S_FINISH;
                            end
                            pdga_pkg::JOB_STORE, pdga_pkg::JOB_TEST: begin
                                r_res   <= '{cell_row: 6'(job.row),
                                             cell_column: 6'(job.col),
                                             status: pdga_pkg::ST_STORED,
                                             accepted: 1'b1};
                                r_store <= 1'b1;
                                r_state <= (job.kind == pdga_pkg::JOB_TEST) ? S_SCAN
                                                                            : S_FINISH;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (last_idx) r_state <= S_DRAIN;
                    else r_idx <= r_idx + 1'b1;
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        if (r_hit) begin
                            r_res.status   <= pdga_pkg::ST_TOOCLOSE;
                            r_res.accepted <= 1'b0;
                            r_store        <= 1'b0;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_out    <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/poisson_disc_grid_accept.sv
// A seed is stored with no distance test; a candidate scans the 21 cells of its
// window through the single grid read port and the distance pipeline; a clear
// sweeps all GRID_SIDE*GRID_SIDE cells. The back end takes one job at a time.
// Reset: synchronous active low; after reset a sweep of all GRID_SIDE*GRID_SIDE
// cells empties the grid while no input transfer is taken. Config keeps working.
module poisson_disc_grid_accept #(
    parameter int GRID_SIDE  = pdga_pkg::GRID_SIDE_DEF,
    parameter int COORD_BITS = pdga_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x[13:0], point_y[27:14], zero fill
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // cell_column[5:0], cell_row[11:6], zero fill
    output logic [3:0]  m_axis_tuser,   // accepted[0], status[3:1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SIDE_BITS = $clog2(GRID_SIDE);
    localparam int JOB_W     = 2 + 3 + 2 * COORD_BITS + 2 * SIDE_BITS;

    pdga_pkg::t_cfg    r_cfg;
    pdga_pkg::t_result result;
    logic              init_done;
    logic              q_in_valid;
    logic              q_in_ready;
    logic [JOB_W-1:0]  q_in_data;
    logic              q_out_valid;
    logic              q_out_ready;
    logic [JOB_W-1:0]  q_out_data;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance    <= pdga_pkg::RST_MIN_DISTANCE;
            r_cfg.map_width       <= pdga_pkg::RST_MAP_WIDTH;
            r_cfg.map_height      <= pdga_pkg::RST_MAP_HEIGHT;
            r_cfg.cell_reciprocal <= pdga_pkg::RST_CELL_RECIPROCAL;
            r_cfg.grid_columns    <= pdga_pkg::RST_GRID_COLUMNS;
            r_cfg.grid_rows       <= pdga_pkg::RST_GRID_ROWS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pdga_pkg::REG_MIN_DISTANCE:    r_cfg.min_distance    <= i_cfg_data[11:0];
                pdga_pkg::REG_MAP_WIDTH:       r_cfg.map_width       <= i_cfg_data[12:0];
                pdga_pkg::REG_MAP_HEIGHT:      r_cfg.map_height      <= i_cfg_data[12:0];
                pdga_pkg::REG_CELL_RECIPROCAL: r_cfg.cell_reciprocal <= i_cfg_data;
                pdga_pkg::REG_GRID_COLUMNS:    r_cfg.grid_columns    <= i_cfg_data[6:0];
                pdga_pkg::REG_GRID_ROWS:       r_cfg.grid_rows       <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    pdga_front #(.GRID_SIDE(GRID_SIDE), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_enable    (init_done),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_point_x   (s_axis_tdata[13:0]),
        .i_point_y   (s_axis_tdata[27:14]),
        .o_job_valid (q_in_valid),
        .i_job_ready (q_in_ready),
        .o_job       (q_in_data)
    );

    pdga_queue #(.W(JOB_W)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_in_valid),
        .o_push_ready (q_in_ready),
        .i_push_data  (q_in_data),
        .o_pop_valid  (q_out_valid),
        .i_pop_ready  (q_out_ready),
        .o_pop_data   (q_out_data)
    );

    pdga_back #(.GRID_SIDE(GRID_SIDE), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .o_ready_init (init_done),
        .i_job_valid  (q_out_valid),
        .o_job_ready  (q_out_ready),
        .i_job        (q_out_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = {4'b0000, result.cell_row, result.cell_column};
    assign m_axis_tuser = {result.status, result.accepted};

endmodule

FILE: design/pdga_checker.sv
// Port-level checks of the Poisson disc grid acceptance engine.
// Depends on pdga_pkg and the top level's ports; bound to poisson_disc_grid_accept.
module pdga_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    // An accepted point always reports the stored status.
    a_accept_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:1] == pdga_pkg::ST_STORED)
        else $error("accepted result without stored status");

    // Clear, outside map and off-grid results carry no cell.
    a_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] == pdga_pkg::ST_CLEARED
            || m_axis_tuser[3:1] == pdga_pkg::ST_OUTSIDE
            || m_axis_tuser[3:1] == pdga_pkg::ST_OFFGRID)
        |-> m_axis_tdata == 16'h0000 && !m_axis_tuser[0])
        else $error("rejected or clear result carries a cell");

    // Nothing is shown right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind poisson_disc_grid_accept pdga_checker u_pdga_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
